// ----- hdl/acps_pkg.sv -----
package acps_pkg;

  localparam int OFF_W = 40;
  localparam int LEN_W = 32;
  localparam int DIV_W = 40;
  localparam int DIV_LANES = 2;
  localparam int BS_W = 13;
  localparam int LBA_W = 28;
  localparam int PC_W = 5;
  localparam int PORT_W = 10;

  localparam logic [BS_W-1:0] BLOCK_MAX = 13'd4096;
  localparam logic [BS_W-1:0] BLOCK_RESET = 13'd512;

  localparam logic [PORT_W-1:0] BASE_PRI = 10'h1F0;
  localparam logic [PORT_W-1:0] BASE_SEC = 10'h170;
  localparam logic [PORT_W-1:0] CTRL_PRI = 10'h3F6;
  localparam logic [PORT_W-1:0] CTRL_SEC = 10'h376;
  localparam logic [7:0] DRIVE_FLAGS = 8'hE0;
  localparam logic [7:0] CTRL_NOINT = 8'h02;
  localparam logic [7:0] CMD_WRITE = 8'h30;
  localparam logic [7:0] CMD_READ = 8'h20;
  localparam logic [7:0] CMD_FLUSH = 8'hE7;
  localparam logic [7:0] ST_ERR = 8'h01;
  localparam logic [7:0] ST_DF = 8'h20;
  localparam logic [7:0] ST_DRQ = 8'h08;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_REQ = 2'd1;
  localparam logic [1:0] ERR_DEV = 2'd2;

  typedef enum logic [1:0] {
    KIND_REQ    = 2'd0,
    KIND_ISSUE  = 2'd1,
    KIND_DONE   = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    CFG_DISK_SELECT  = 2'd0,
    CFG_SECTOR_BYTES = 2'd1,
    CFG_DISK_SECTORS = 2'd2
  } cfg_reg_t;

  typedef enum logic [3:0] {
    F_NONE  = 4'd0,
    F_DRIVE = 4'd1,
    F_CTRL  = 4'd2,
    F_FEAT  = 4'd3,
    F_COUNT = 4'd4,
    F_LBA0  = 4'd5,
    F_LBA1  = 4'd6,
    F_LBA2  = 4'd7,
    F_CMD   = 4'd8,
    F_FLUSH = 4'd9
  } fld_t;

  typedef enum logic [1:0] {
    E_ZERO   = 2'd0,
    E_ONE    = 2'd1,
    E_REQ    = 2'd2,
    E_STATUS = 2'd3
  } err_sel_t;

  typedef enum logic [2:0] {
    A_NONE    = 3'd0,
    A_DIV     = 3'd1,
    A_OPEN    = 3'd2,
    A_ISSUE   = 3'd3,
    A_ADVANCE = 3'd4,
    A_STATUS  = 3'd5
  } act_t;

  typedef enum logic [2:0] {
    C_NEXT      = 3'd0,
    C_KIND      = 3'd1,
    C_DIVWAIT   = 3'd2,
    C_IFINACT   = 3'd3,
    C_IFNOCHUNK = 3'd4,
    C_END       = 3'd5
  } cond_t;

  typedef struct packed {
    logic            emit;
    logic            last;
    logic            done;
    fld_t            fld;
    err_sel_t        err;
    act_t            act;
    cond_t           cond;
    logic [PC_W-1:0] target;
  } ctl_word_t;

  typedef struct packed {
    kind_t kind;
    logic  div_busy;
    logic  inactive;
    logic  nochunk;
    logic  slot_free;
  } seq_flags_t;

  localparam logic [PC_W-1:0] ENTRY_REQ = 5'd1;
  localparam logic [PC_W-1:0] ENTRY_ISSUE = 5'd4;
  localparam logic [PC_W-1:0] ENTRY_ERR = 5'd13;
  localparam logic [PC_W-1:0] ENTRY_DONE = 5'd14;
  localparam logic [PC_W-1:0] ENTRY_STATUS = 5'd16;

  function automatic ctl_word_t mk(logic emit, logic last, logic done, fld_t fld,
                                   err_sel_t err, act_t act, cond_t cond,
                                   logic [PC_W-1:0] target);
    ctl_word_t w;
    w.emit = emit;
    w.last = last;
    w.done = done;
    w.fld = fld;
    w.err = err;
    w.act = act;
    w.cond = cond;
    w.target = target;
    return w;
  endfunction

  // microcode store
  function automatic ctl_word_t urom(logic [PC_W-1:0] pc);
    ctl_word_t w;
    unique case (pc)
      5'd0:  w = mk(1'b0, 1'b0, 1'b0, F_NONE,  E_ZERO,   A_NONE,    C_KIND,      5'd0);
      5'd1:  w = mk(1'b0, 1'b0, 1'b0, F_NONE,  E_ZERO,   A_DIV,     C_NEXT,      5'd0);
      5'd2:  w = mk(1'b0, 1'b0, 1'b0, F_NONE,  E_ZERO,   A_NONE,    C_DIVWAIT,   5'd0);
      5'd3:  w = mk(1'b1, 1'b1, 1'b0, F_NONE,  E_REQ,    A_OPEN,    C_END,       5'd0);
      5'd4:  w = mk(1'b0, 1'b0, 1'b0, F_NONE,  E_ZERO,   A_NONE,    C_IFINACT,   ENTRY_ERR);
      5'd5:  w = mk(1'b1, 1'b0, 1'b0, F_DRIVE, E_ZERO,   A_ISSUE,   C_NEXT,      5'd0);
      5'd6:  w = mk(1'b1, 1'b0, 1'b0, F_CTRL,  E_ZERO,   A_NONE,    C_NEXT,      5'd0);
      5'd7:  w = mk(1'b1, 1'b0, 1'b0, F_FEAT,  E_ZERO,   A_NONE,    C_NEXT,      5'd0);
      5'd8:  w = mk(1'b1, 1'b0, 1'b0, F_COUNT, E_ZERO,   A_NONE,    C_NEXT,      5'd0);
      5'd9:  w = mk(1'b1, 1'b0, 1'b0, F_LBA0,  E_ZERO,   A_NONE,    C_NEXT,      5'd0);
      5'd10: w = mk(1'b1, 1'b0, 1'b0, F_LBA1,  E_ZERO,   A_NONE,    C_NEXT,      5'd0);
      5'd11: w = mk(1'b1, 1'b0, 1'b0, F_LBA2,  E_ZERO,   A_NONE,    C_NEXT,      5'd0);
      5'd12: w = mk(1'b1, 1'b1, 1'b0, F_CMD,   E_ZERO,   A_NONE,    C_END,       5'd0);
      5'd13: w = mk(1'b1, 1'b1, 1'b0, F_NONE,  E_ONE,    A_NONE,    C_END,       5'd0);
      5'd14: w = mk(1'b0, 1'b0, 1'b0, F_NONE,  E_ZERO,   A_NONE,    C_IFNOCHUNK, ENTRY_ERR);
      5'd15: w = mk(1'b1, 1'b1, 1'b1, F_FLUSH, E_ZERO,   A_ADVANCE, C_END,       5'd0);
      5'd16: w = mk(1'b1, 1'b1, 1'b0, F_NONE,  E_STATUS, A_STATUS,  C_END,       5'd0);
      default: w = mk(1'b0, 1'b0, 1'b0, F_NONE, E_ZERO,  A_NONE,    C_END,       5'd0);
    endcase
    return w;
  endfunction

endpackage

// ----- hdl/acps_div.sv -----
module acps_div
  import acps_pkg::*;
(
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic [BS_W-1:0]                     divisor,
  input  logic [DIV_LANES-1:0][DIV_W-1:0]     dividend,
  output logic                                busy,
  output logic [DIV_LANES-1:0][DIV_W-1:0]     quotient,
  output logic [DIV_LANES-1:0][BS_W-1:0]      remainder
);

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic [CNT_W-1:0] count;
  logic [BS_W-1:0] dvs;
  logic [DIV_LANES-1:0][DIV_W-1:0] quo_next;
  logic [DIV_LANES-1:0][BS_W-1:0] rem_next;

  // one quotient bit per lane per cycle, restoring
  always_comb begin
    for (int i = 0; i < DIV_LANES; i++) begin
      logic [BS_W:0] trial;
      trial = {remainder[i], quotient[i][DIV_W-1]};
      if (trial >= {1'b0, dvs}) begin
        rem_next[i] = BS_W'(trial - {1'b0, dvs});
        quo_next[i] = {quotient[i][DIV_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[BS_W-1:0];
        quo_next[i] = {quotient[i][DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy <= 1'b1;
      count <= CNT_W'(DIV_W);
    end else if (busy) begin
      count <= count - 1'b1;
      busy <= (count != CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvs <= divisor;
      quotient <= dividend;
      remainder <= '0;
    end else if (busy) begin
      quotient <= quo_next;
      remainder <= rem_next;
    end
  end

endmodule

// ----- hdl/acps_seq.sv -----
module acps_seq
  import acps_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  seq_flags_t flags,
  output logic       busy,
  output logic       fire,
  output ctl_word_t  word
);

  logic [PC_W-1:0] pc;
  logic hold;

  assign word = urom(pc);
  assign hold = (word.emit && !flags.slot_free) ||
                (word.cond == C_DIVWAIT && flags.div_busy);
  assign fire = busy && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= '0;
    end else if (!busy) begin
      if (start) begin
        busy <= 1'b1;
        pc <= '0;
      end
    end else if (!hold) begin
      unique case (word.cond) inside
        C_NEXT, C_DIVWAIT: pc <= pc + 1'b1;
        C_KIND: begin
          unique case (flags.kind)
            KIND_REQ:    pc <= ENTRY_REQ;
            KIND_ISSUE:  pc <= ENTRY_ISSUE;
            KIND_DONE:   pc <= ENTRY_DONE;
            KIND_STATUS: pc <= ENTRY_STATUS;
            default:     pc <= ENTRY_ERR;
          endcase
        end
        C_IFINACT:   pc <= flags.inactive ? word.target : pc + 1'b1;
        C_IFNOCHUNK: pc <= flags.nochunk ? word.target : pc + 1'b1;
        C_END: begin
          busy <= 1'b0;
          pc <= '0;
        end
        default: begin
          busy <= 1'b0;
          pc <= '0;
        end
      endcase
    end
  end

endmodule

// ----- hdl/ata_pio_command_sequencer_top.sv -----
// Host-side ATA PIO LBA28 command issuer driven by a small microcode store.
// Each input transfer carries a kind in s_tuser: a new request is checked
// for block alignment, size and capacity by a bit-serial divider and gives
// one result. A next-chunk item gives the eight task-file register writes,
// one result per cycle unless the output stalls, or one error result if no
// transfer is open. Chunk-done and a status check each give one result. One
// item is worked on at a time; s_tready is low while the microprogram runs,
// and a full output register stalls the step counter. The user must write
// configuration through cfg_we only while idle; the block does not check.
module ata_pio_command_sequencer_top
  import acps_pkg::*;
#(
  parameter int MAX_CHUNK = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // byte_offset[39:0], byte_length[71:40], is_write[72], status_byte[80:73]
  input  logic [87:0] s_tdata,
  // kind
  input  logic [1:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // has_write[0], port[10:1], value[18:11], error_code[20:19], done_res[21]
  output logic [23:0] m_tdata,
  output logic        m_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [27:0] cfg_data
);

  localparam logic [7:0] MaxChunkB = 8'(MAX_CHUNK);

  logic [1:0] disk_select;
  logic [BS_W-1:0] sector_bytes;
  logic [LBA_W-1:0] disk_sectors;

  logic active;
  logic write_dir;
  logic [LBA_W-1:0] current_lba;
  logic [31:0] remaining_sectors;
  logic [7:0] chunk_sectors;

  kind_t kind_q;
  logic [OFF_W-1:0] offset_q;
  logic [LEN_W-1:0] length_q;
  logic is_write_q;
  logic [7:0] status_q;

  logic seq_busy;
  logic fire;
  ctl_word_t word;
  seq_flags_t flags;

  logic div_busy;
  logic [DIV_LANES-1:0][DIV_W-1:0] dividend;
  logic [DIV_LANES-1:0][DIV_W-1:0] quotient;
  logic [DIV_LANES-1:0][BS_W-1:0] remainder;

  logic in_xfer;
  logic slot_free;
  logic req_valid;
  logic st_bad;
  logic [32:0] req_end;
  logic [PORT_W-1:0] base;
  logic [PORT_W-1:0] ctrl;

  logic res_hw;
  logic [PORT_W-1:0] res_port;
  logic [7:0] res_value;
  logic [1:0] res_err;
  logic res_done;

  assign s_tready = !seq_busy;
  assign in_xfer = s_tvalid && s_tready;
  assign slot_free = !m_tvalid || m_tready;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      disk_select <= '0;
      sector_bytes <= BLOCK_RESET;
      disk_sectors <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DISK_SELECT:  disk_select <= cfg_data[1:0];
        CFG_SECTOR_BYTES: sector_bytes <= cfg_data[BS_W-1:0];
        CFG_DISK_SECTORS: disk_sectors <= cfg_data[LBA_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      kind_q <= kind_t'(s_tuser);
      offset_q <= s_tdata[39:0];
      length_q <= s_tdata[71:40];
      is_write_q <= s_tdata[72];
      status_q <= s_tdata[80:73];
    end
  end

  assign flags.kind = kind_q;
  assign flags.div_busy = div_busy;
  assign flags.inactive = !active;
  assign flags.nochunk = !active || (chunk_sectors == '0);
  assign flags.slot_free = slot_free;

  acps_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (in_xfer),
    .flags (flags),
    .busy  (seq_busy),
    .fire  (fire),
    .word  (word)
  );

  assign dividend[0] = offset_q;
  assign dividend[1] = DIV_W'(length_q);

  acps_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (fire && word.act == A_DIV),
    .divisor   (sector_bytes),
    .dividend  (dividend),
    .busy      (div_busy),
    .quotient  (quotient),
    .remainder (remainder)
  );

  // request check on the quotients
  assign req_end = {5'b0, quotient[0][LBA_W-1:0]} + {1'b0, quotient[1][LEN_W-1:0]};
  assign req_valid = (sector_bytes != '0) && (sector_bytes <= BLOCK_MAX) &&
                     (remainder[0] == '0) && (remainder[1] == '0) &&
                     (quotient[1][LEN_W-1:0] != '0) &&
                     (quotient[0][DIV_W-1:LBA_W] == '0) &&
                     (req_end < {5'b0, disk_sectors});

  assign st_bad = ((status_q & ST_ERR) != '0) || ((status_q & ST_DF) != '0) ||
                  ((status_q & ST_DRQ) == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      write_dir <= 1'b0;
      current_lba <= '0;
      remaining_sectors <= '0;
      chunk_sectors <= '0;
    end else if (fire) begin
      case (word.act)
        A_OPEN: begin
          active <= req_valid;
          if (req_valid) begin
            write_dir <= is_write_q;
            current_lba <= quotient[0][LBA_W-1:0];
            remaining_sectors <= quotient[1][LEN_W-1:0];
            chunk_sectors <= '0;
          end
        end
        A_ISSUE: begin
          chunk_sectors <= (remaining_sectors <= 32'(MAX_CHUNK)) ?
                           remaining_sectors[7:0] : MaxChunkB;
        end
        A_ADVANCE: begin
          current_lba <= current_lba + LBA_W'(chunk_sectors);
          remaining_sectors <= remaining_sectors - 32'(chunk_sectors);
          chunk_sectors <= '0;
          if (remaining_sectors == 32'(chunk_sectors)) begin
            active <= 1'b0;
          end
        end
        A_STATUS: begin
          if (st_bad) begin
            active <= 1'b0;
            chunk_sectors <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result fields
  assign base = disk_select[1] ? BASE_SEC : BASE_PRI;
  assign ctrl = disk_select[1] ? CTRL_SEC : CTRL_PRI;

  always_comb begin
    res_hw = 1'b1;
    res_port = '0;
    res_value = '0;
    unique case (word.fld)
      F_DRIVE: begin
        res_port = base + PORT_W'(6);
        res_value = DRIVE_FLAGS | {3'b0, disk_select[0], current_lba[27:24]};
      end
      F_CTRL: begin
        res_port = ctrl;
        res_value = CTRL_NOINT;
      end
      F_FEAT:  res_port = base + PORT_W'(1);
      F_COUNT: begin
        res_port = base + PORT_W'(2);
        res_value = chunk_sectors;
      end
      F_LBA0: begin
        res_port = base + PORT_W'(3);
        res_value = current_lba[7:0];
      end
      F_LBA1: begin
        res_port = base + PORT_W'(4);
        res_value = current_lba[15:8];
      end
      F_LBA2: begin
        res_port = base + PORT_W'(5);
        res_value = current_lba[23:16];
      end
      F_CMD: begin
        res_port = base + PORT_W'(7);
        res_value = write_dir ? CMD_WRITE : CMD_READ;
      end
      F_FLUSH: begin
        res_hw = write_dir;
        res_port = write_dir ? base + PORT_W'(7) : '0;
        res_value = write_dir ? CMD_FLUSH : '0;
      end
      default: res_hw = 1'b0;
    endcase
  end

  always_comb begin
    case (word.err)
      E_ONE:    res_err = ERR_REQ;
      E_REQ:    res_err = req_valid ? ERR_NONE : ERR_REQ;
      E_STATUS: res_err = st_bad ? ERR_DEV : ERR_NONE;
      default:  res_err = ERR_NONE;
    endcase
  end

  assign res_done = word.done && (remaining_sectors == 32'(chunk_sectors));

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire && word.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && word.emit) begin
      m_tdata <= {2'b0, res_done, res_err, res_value, res_port, res_hw};
      m_tlast <= word.last;
    end
  end

  a_chunk_within_remaining: assert property (@(posedge clk) disable iff (rst)
    32'(chunk_sectors) <= remaining_sectors)
    else $error("chunk exceeds remaining sectors");

  a_active_has_sectors: assert property (@(posedge clk) disable iff (rst)
    active |-> remaining_sectors != '0)
    else $error("open transfer with no sectors left");

  a_div_starts: assert property (@(posedge clk) disable iff (rst)
    (fire && word.act == A_DIV) |=> div_busy)
    else $error("divider did not start");

endmodule

// ----- dv/tb_ata_pio_command_sequencer_top.sv -----
`timescale 1ns / 1ps

module tb_ata_pio_command_sequencer_top;
  import acps_pkg::*;

  localparam int CHUNK_MAX = 255;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [27:0] LBA_TOP = 28'hFFFFFFF;

  typedef struct packed {
    logic              hw;
    logic [PORT_W-1:0] port;
    logic [7:0]        val;
    logic [1:0]        err;
    logic              done;
    logic              last;
  } tf_res_t;

  typedef struct {
    logic        is_cfg;
    cfg_reg_t    idx;
    logic [27:0] cval;
    kind_t       kind;
    logic [39:0] off;
    logic [31:0] len;
    logic        wr;
    logic [7:0]  st;
    logic        fixed;
    logic [1:0]  err;
  } dir_row_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [87:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [27:0] cfg_data;

  // register copies and transfer state
  logic [1:0]  sel_r;
  logic [12:0] bs_r;
  logic [27:0] cap_r;
  logic        act_r;
  logic        wr_r;
  logic [27:0] lba_r;
  logic [31:0] rem_r;
  logic [7:0]  chunk_r;

  tf_res_t  taskfile_q[$];
  dir_row_t dir_tab[$];
  tf_res_t  got_w;
  tf_res_t  want_w;
  int       fault_n = 0;
  int       items_n;
  int       cyc_n = 0;
  int       stall_left = 0;
  bit       gaps_on;

  ata_pio_command_sequencer_top #(
    .MAX_CHUNK(CHUNK_MAX)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic tf_res_t res(logic hw, logic [PORT_W-1:0] port, logic [7:0] val,
                                  logic [1:0] err, logic done, logic last);
    tf_res_t r;
    r.hw = hw;
    r.port = port;
    r.val = val;
    r.err = err;
    r.done = done;
    r.last = last;
    return r;
  endfunction

  function automatic logic [39:0] rand40();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[39:0];
  endfunction

  function automatic logic rand_bit();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] good_status();
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    return (s | ST_DRQ) & ~(ST_ERR | ST_DF);
  endfunction

  function automatic logic [7:0] bad_status();
    logic [7:0] s;
    s = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 2))
      0: s = s | ST_ERR;
      1: s = s | ST_DF;
      default: s = s & ~ST_DRQ;
    endcase
    return s;
  endfunction

  task automatic note(input tf_res_t r, input bit keep);
    if (keep) taskfile_q.push_back(r);
  endtask

  // one command through the sequencer
  task automatic ata_step(input kind_t k, input logic [39:0] off, input logic [31:0] len,
                          input logic wr, input logic [7:0] st, input bit keep);
    logic [PORT_W-1:0] base;
    logic [PORT_W-1:0] ctrl;
    logic [63:0]       off64;
    logic [63:0]       len64;
    logic [63:0]       bs64;
    logic [63:0]       sect;
    logic [63:0]       cnt;
    logic [7:0]        c;
    logic              ok;
    logic              fin;
    base = sel_r[1] ? BASE_SEC : BASE_PRI;
    ctrl = sel_r[1] ? CTRL_SEC : CTRL_PRI;
    off64 = {24'd0, off};
    len64 = {32'd0, len};
    bs64 = {51'd0, bs_r};
    sect = '0;
    cnt = '0;
    case (k)
      KIND_REQ: begin
        ok = 1'b1;
        if (bs_r == 0 || bs_r > BLOCK_MAX) begin
          ok = 1'b0;
        end else if (off64 % bs64 != 0 || len64 % bs64 != 0) begin
          ok = 1'b0;
        end else begin
          sect = off64 / bs64;
          cnt = len64 / bs64;
          if (cnt == 0 || sect > {36'd0, LBA_TOP} || sect + cnt >= {36'd0, cap_r}) ok = 1'b0;
        end
        if (ok) begin
          act_r = 1'b1;
          wr_r = wr;
          lba_r = sect[27:0];
          rem_r = cnt[31:0];
          chunk_r = '0;
          note(res(1'b0, '0, '0, ERR_NONE, 1'b0, 1'b1), keep);
        end else begin
          act_r = 1'b0;
          note(res(1'b0, '0, '0, ERR_REQ, 1'b0, 1'b1), keep);
        end
      end
      KIND_ISSUE: begin
        if (!act_r) begin
          note(res(1'b0, '0, '0, ERR_REQ, 1'b0, 1'b1), keep);
        end else begin
          c = (rem_r <= CHUNK_MAX) ? rem_r[7:0] : 8'(CHUNK_MAX);
          chunk_r = c;
          note(res(1'b1, base + 10'd6, DRIVE_FLAGS | {3'b000, sel_r[0], lba_r[27:24]},
                   ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, ctrl, CTRL_NOINT, ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, base + 10'd1, 8'h00, ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, base + 10'd2, c, ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, base + 10'd3, lba_r[7:0], ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, base + 10'd4, lba_r[15:8], ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, base + 10'd5, lba_r[23:16], ERR_NONE, 1'b0, 1'b0), keep);
          note(res(1'b1, base + 10'd7, wr_r ? CMD_WRITE : CMD_READ, ERR_NONE, 1'b0, 1'b1),
               keep);
        end
      end
      KIND_DONE: begin
        if (!act_r || chunk_r == 0) begin
          note(res(1'b0, '0, '0, ERR_REQ, 1'b0, 1'b1), keep);
        end else begin
          lba_r = lba_r + {20'd0, chunk_r};
          rem_r = rem_r - {24'd0, chunk_r};
          chunk_r = '0;
          fin = (rem_r == 0);
          if (fin) act_r = 1'b0;
          if (wr_r) note(res(1'b1, base + 10'd7, CMD_FLUSH, ERR_NONE, fin, 1'b1), keep);
          else note(res(1'b0, '0, '0, ERR_NONE, fin, 1'b1), keep);
        end
      end
      default: begin
        if ((st & ST_ERR) != 0 || (st & ST_DF) != 0 || (st & ST_DRQ) == 0) begin
          act_r = 1'b0;
          chunk_r = '0;
          note(res(1'b0, '0, '0, ERR_DEV, 1'b0, 1'b1), keep);
        end else begin
          note(res(1'b0, '0, '0, ERR_NONE, 1'b0, 1'b1), keep);
        end
      end
    endcase
  endtask

  task automatic send(input kind_t k, input logic [39:0] off, input logic [31:0] len,
                      input logic wr, input logic [7:0] st, input bit keep);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= k;
    s_tdata <= {7'd0, st, wr, len, off};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_n++;
    ata_step(k, off, len, wr, st, keep);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (taskfile_q.size() != 0 || !s_tready) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_reg_t idx, input logic [27:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    case (idx)
      CFG_DISK_SELECT: sel_r = v[1:0];
      CFG_SECTOR_BYTES: bs_r = v[12:0];
      default: cap_r = v;
    endcase
  endtask

  task automatic load_regs(input logic [1:0] ds, input logic [12:0] bs,
                           input logic [27:0] sec);
    wait_idle();
    set_reg(CFG_DISK_SELECT, {26'd0, ds});
    set_reg(CFG_SECTOR_BYTES, {15'd0, bs});
    set_reg(CFG_DISK_SECTORS, sec);
    cfg_we <= 1'b0;
  endtask

  task automatic row_cfg(input cfg_reg_t idx, input logic [27:0] v);
    dir_row_t r;
    r = '{1'b1, idx, v, KIND_REQ, '0, '0, 1'b0, '0, 1'b0, ERR_NONE};
    dir_tab.push_back(r);
  endtask

  task automatic row_item(input kind_t k, input logic [39:0] off, input logic [31:0] len,
                          input logic wr, input logic [7:0] st, input bit fixed,
                          input logic [1:0] err);
    dir_row_t r;
    r = '{1'b0, CFG_DISK_SELECT, '0, k, off, len, wr, st, fixed, err};
    dir_tab.push_back(r);
  endtask

  // a well-formed transfer with random content
  task automatic run_transfer();
    logic [63:0] cnt;
    logic [63:0] sect;
    logic [63:0] off_v;
    logic [63:0] len_v;
    case ($urandom_range(0, 5))
      0: cnt = 64'($urandom_range(1, 10));
      1: cnt = 64'(CHUNK_MAX);
      2: cnt = 64'(CHUNK_MAX + 1);
      3: cnt = 64'($urandom_range(256, 700));
      default: cnt = 64'($urandom_range(1, 254));
    endcase
    if ({36'd0, cap_r} > cnt) begin
      if ($urandom_range(0, 4) == 0) sect = {36'd0, cap_r} - cnt - 1;
      else sect = {32'd0, $urandom} % ({36'd0, cap_r} - cnt);
    end else begin
      sect = 64'($urandom_range(0, 100));
    end
    off_v = sect * {51'd0, bs_r};
    len_v = cnt * {51'd0, bs_r};
    send(KIND_REQ, off_v[39:0], len_v[31:0], rand_bit(), rand_byte(), 1'b1);
    while (act_r) begin
      send(KIND_ISSUE, rand40(), $urandom, rand_bit(), rand_byte(), 1'b1);
      if ($urandom_range(0, 7) == 0)
        send(KIND_ISSUE, rand40(), $urandom, rand_bit(), rand_byte(), 1'b1);
      if ($urandom_range(0, 3) == 0)
        send(KIND_STATUS, rand40(), $urandom, rand_bit(), good_status(), 1'b1);
      if ($urandom_range(0, 24) == 0)
        send(KIND_STATUS, rand40(), $urandom, rand_bit(), bad_status(), 1'b1);
      if (act_r)
        send(KIND_DONE, rand40(), $urandom, rand_bit(), rand_byte(), 1'b1);
    end
  endtask

  task automatic noise_item();
    logic [1:0] k;
    k = 2'($urandom_range(0, 3));
    send(kind_t'(k), rand40(), $urandom, rand_bit(), rand_byte(), 1'b1);
  endtask

  // result side: random stalls and comparison
  always @(posedge clk) begin
    cyc_n++;
    if (cyc_n >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_w.hw = m_tdata[0];
        got_w.port = m_tdata[10:1];
        got_w.val = m_tdata[18:11];
        got_w.err = m_tdata[20:19];
        got_w.done = m_tdata[21];
        got_w.last = m_tlast;
        if (taskfile_q.size() == 0) begin
          fault_n++;
          $display("%0t: unexpected hw=%b port=%h val=%h err=%0d done=%b last=%b",
                   $time, got_w.hw, got_w.port, got_w.val, got_w.err, got_w.done, got_w.last);
        end else begin
          want_w = taskfile_q.pop_front();
          if (got_w !== want_w) begin
            fault_n++;
            $display("%0t: expected hw=%b port=%h val=%h err=%0d done=%b last=%b", $time,
                     want_w.hw, want_w.port, want_w.val, want_w.err, want_w.done, want_w.last);
            $display("%0t: actual   hw=%b port=%h val=%h err=%0d done=%b last=%b", $time,
                     got_w.hw, got_w.port, got_w.val, got_w.err, got_w.done, got_w.last);
          end
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  initial begin
    bit cfg_open;
    int target;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= KIND_REQ;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DISK_SELECT;
    cfg_data <= '0;
    sel_r = '0;
    bs_r = BLOCK_RESET;
    cap_r = '0;
    act_r = 1'b0;
    wr_r = 1'b0;
    lba_r = '0;
    rem_r = '0;
    chunk_r = '0;
    items_n = 0;
    gaps_on = 1'b1;
    cfg_open = 1'b0;

    // no transfer open, capacity zero after reset
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    row_item(KIND_DONE, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    row_item(KIND_STATUS, '0, '0, 1'b0, 8'h08, 1, ERR_NONE);
    row_item(KIND_STATUS, '0, '0, 1'b0, 8'h00, 1, ERR_DEV);
    row_item(KIND_REQ, '0, 32'd512, 1'b0, 8'h00, 1, ERR_REQ);
    row_cfg(CFG_DISK_SECTORS, LBA_TOP);
    row_cfg(CFG_DISK_SELECT, 28'd3);
    // empty, misaligned, beyond lba range, beyond capacity
    row_item(KIND_REQ, '0, '0, 1'b1, 8'h00, 1, ERR_REQ);
    row_item(KIND_REQ, 40'hFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 8'hFF, 1, ERR_REQ);
    row_item(KIND_REQ, 40'h20_0000_0000, 32'd512, 1'b0, 8'h00, 1, ERR_REQ);
    row_item(KIND_REQ, 40'h1F_FFFF_FE00, 32'd512, 1'b0, 8'h00, 1, ERR_REQ);
    // top of the lba range, write, chunk reissued
    row_item(KIND_REQ, 40'h1F_FFFF_FA00, 32'd512, 1'b1, 8'h00, 0, ERR_NONE);
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_DONE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_DONE, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    row_cfg(CFG_DISK_SELECT, 28'd0);
    // 600 sector read, split and then abandoned on a device fault
    row_item(KIND_REQ, 40'h0F_1234_5600, 32'h0004_B000, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_DONE, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_STATUS, '0, '0, 1'b0, 8'h58, 1, ERR_NONE);
    row_item(KIND_DONE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_STATUS, '0, '0, 1'b0, 8'h28, 1, ERR_DEV);
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    // block size out of range
    row_cfg(CFG_SECTOR_BYTES, 28'd0);
    row_item(KIND_REQ, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    row_cfg(CFG_SECTOR_BYTES, 28'h1FFF);
    row_item(KIND_REQ, '0, '0, 1'b0, 8'h00, 1, ERR_REQ);
    // block size of two bytes on the slave drive
    row_cfg(CFG_SECTOR_BYTES, 28'd2);
    row_cfg(CFG_DISK_SELECT, 28'd1);
    row_item(KIND_REQ, 40'd2, 32'd4, 1'b1, 8'h00, 0, ERR_NONE);
    row_item(KIND_ISSUE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);
    row_item(KIND_DONE, '0, '0, 1'b0, 8'h00, 0, ERR_NONE);

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) begin
        if (!cfg_open) wait_idle();
        set_reg(dir_tab[i].idx, dir_tab[i].cval);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_we <= 1'b0;
          cfg_open = 1'b0;
        end
        send(dir_tab[i].kind, dir_tab[i].off, dir_tab[i].len, dir_tab[i].wr, dir_tab[i].st,
             !dir_tab[i].fixed);
        if (dir_tab[i].fixed)
          taskfile_q.push_back(res(1'b0, '0, '0, dir_tab[i].err, 1'b0, 1'b1));
      end
    end

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: load_regs(2'd3, 13'd4096, LBA_TOP);
        1: load_regs(2'd0, 13'd2, LBA_TOP);
        2: load_regs(2'd2, 13'($urandom_range(2, 4096)),
                     28'($urandom_range(1000, 28'hFFFFFFF)));
        3: load_regs(2'd1, 13'd512, 28'd600);
        4: load_regs(2'($urandom_range(0, 3)), 13'($urandom_range(2, 4096)), LBA_TOP);
        default: load_regs(2'd1, 13'($urandom_range(2, 4096)),
                           28'($urandom_range(1000, 28'hFFFFFFF)));
      endcase
      gaps_on = (p != 4 && p != 5);
      target = items_n + 28;
      while (items_n < target) begin
        case ($urandom_range(0, 9))
          7: noise_item();
          8: begin
            wait_idle();
            run_transfer();
          end
          default: run_transfer();
        endcase
      end
    end

    s_tvalid <= 1'b0;
    while (taskfile_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fault_n == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
